@@ rtl/xlz_pkg.sv @@
// Shared types and constants for the Xpress LZ77 decompressor.
// No dependencies; every other file imports this package.
package xlz_pkg;

    localparam int unsigned CountW = 17;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_COPY_BUSY = 3'd1,
        ST_BAD_DIST  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_PAST_LIM  = 3'd4
    } t_status;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef enum logic [9:0] {
        PH_FLAG0    = 10'b00_0000_0001,
        PH_FLAG1    = 10'b00_0000_0010,
        PH_FLAG2    = 10'b00_0000_0100,
        PH_FLAG3    = 10'b00_0000_1000,
        PH_DATA     = 10'b00_0001_0000,
        PH_TOK_HI   = 10'b00_0010_0000,
        PH_NIBBLE   = 10'b00_0100_0000,
        PH_EXT_BYTE = 10'b00_1000_0000,
        PH_EXT16_LO = 10'b01_0000_0000,
        PH_EXT16_HI = 10'b10_0000_0000
    } t_phase;

    localparam logic [1:0] RegOutputLimit = 2'd0;

endpackage

@@ rtl/xlz_front.sv @@
// Input side of the decompressor: a two-entry queue that takes requests and
// tags them as compressed bytes or copy ticks. Depends on xlz_pkg.
module xlz_front
    import xlz_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_item_valid,
    input  logic       i_item_ready,
    output t_item      o_item
);

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_item      in_item;

    always_comb begin
        in_item.kind = i_req_type ? KIND_TICK : KIND_BYTE;
        in_item.data = i_in_byte;
        in_item.last = i_in_last;
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];
    assign push         = i_valid && o_ready;
    assign pop          = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= in_item;
    end

endmodule

@@ rtl/xlz_back.sv @@
// Decode engine: parser state, history RAM and the result register.
// Depends on xlz_pkg; fed by xlz_front.
module xlz_back
    import xlz_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH   = 8192,
    parameter int unsigned MAX_BLOCK_BYTES = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  t_item             i_item,
    input  logic [CountW-1:0] i_limit,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_copy_pending,
    output logic              o_block_done,
    output logic [2:0]        o_status,
    output logic [CountW-1:0] o_decoded_count
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam logic [CountW-1:0] LimMax = CountW'(MAX_BLOCK_BYTES);
    localparam logic [AW:0] Depth = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LastAddr = AW'(HISTORY_DEPTH - 1);

    // Parser and block state.
    t_phase            r_phase, n_phase;
    logic [31:0]       r_flag_word, n_flag_word;
    logic [5:0]        r_flags_left, n_flags_left;
    logic [7:0]        r_tok_lo, n_tok_lo;
    logic [12:0]       r_dist, n_dist;
    logic [CountW-1:0] r_remain, n_remain;
    logic              r_nib_held, n_nib_held;
    logic [3:0]        r_held_nib, n_held_nib;
    logic [CountW-1:0] r_count, n_count;
    logic [AW-1:0]     r_wp, n_wp;
    logic              r_ended, n_ended;

    // Result stage.
    logic              r_res_valid;
    logic              r_s2_tick, r_s2_lit;
    logic [7:0]        r_s2_lit_byte;
    logic              r_s2_byp;
    logic [7:0]        r_s2_byp_data;
    logic              r_s2_pending, r_s2_done;
    logic [2:0]        r_s2_status;
    logic [CountW-1:0] r_s2_count;
    logic [7:0]        r_rd_data;
    logic              r_wr_pend;
    logic [AW-1:0]     r_wr_addr;

    logic [7:0]        mem [HISTORY_DEPTH];

    logic              advance, take;
    logic              tick_hit, lit_hit, produce;
    logic [2:0]        status;
    logic [CountW-1:0] lim;
    logic [AW-1:0]     rd_addr;
    logic [AW:0]       back_sum;
    logic [7:0]        s2_byte;
    logic              byp;
    logic [15:0]       tok;
    logic [CountW-1:0] mlen;
    logic              do_match;
    logic              flag_reload;

    assign advance      = !r_res_valid || i_ready;
    assign take         = i_item_valid && advance;
    assign o_item_ready = advance;

    assign s2_byte = r_s2_tick ? (r_s2_byp ? r_s2_byp_data : r_rd_data) : r_s2_lit_byte;
    assign lim     = (i_limit > LimMax) ? LimMax : i_limit;

    // Copy source: write pointer minus (distance + 1), wrapped into the window.
    always_comb begin
        back_sum = {1'b0, r_wp} - (AW+1)'({1'b0, r_dist} + 14'd1);
        if ({1'b0, r_wp} < (AW+1)'({1'b0, r_dist} + 14'd1)) back_sum = back_sum + Depth;
        rd_addr = back_sum[AW-1:0];
    end
    assign byp = r_wr_pend && (r_wr_addr == rd_addr);

    always_comb begin
        n_phase      = r_phase;
        n_flag_word  = r_flag_word;
        n_flags_left = r_flags_left;
        n_tok_lo     = r_tok_lo;
        n_dist       = r_dist;
        n_remain     = r_remain;
        n_nib_held   = r_nib_held;
        n_held_nib   = r_held_nib;
        n_count      = r_count;
        n_wp         = r_wp;
        n_ended      = r_ended;
        tick_hit     = 1'b0;
        lit_hit      = 1'b0;
        status       = ST_OK;
        tok          = {i_item.data, r_tok_lo};
        mlen         = '0;
        do_match     = 1'b0;
        flag_reload  = 1'b0;

        if (i_item.kind == KIND_TICK) begin
            if (r_remain != '0) begin
                if (r_count >= lim) begin
                    n_remain = '0;
                end else begin
                    tick_hit = 1'b1;
                    n_count  = r_count + CountW'(1);
                    n_wp     = (r_wp == LastAddr) ? '0 : r_wp + AW'(1);
                    n_remain = r_remain - CountW'(1);
                    if (n_count >= lim) n_remain = '0;
                end
            end
        end else begin
            // A byte after a finished block opens a new block.
            if (r_ended && r_remain == '0) begin
                n_phase      = PH_FLAG0;
                n_flags_left = '0;
                n_nib_held   = 1'b0;
                n_held_nib   = '0;
                n_count      = '0;
                n_wp         = '0;
                n_ended      = 1'b0;
            end
            if (r_remain != '0) begin
                status = ST_COPY_BUSY;
            end else if (n_count >= lim) begin
                status = ST_PAST_LIM;
                if (i_item.last) n_ended = 1'b1;
            end else begin
                unique case (n_phase)
                    PH_FLAG1: begin
                        n_flag_word = r_flag_word | {16'd0, i_item.data, 8'd0};
                        n_phase     = PH_FLAG2;
                    end
                    PH_FLAG2: begin
                        n_flag_word = r_flag_word | {8'd0, i_item.data, 16'd0};
                        n_phase     = PH_FLAG3;
                    end
                    PH_FLAG3: begin
                        n_flag_word  = r_flag_word | {i_item.data, 24'd0};
                        n_flags_left = 6'd32;
                        n_phase      = PH_DATA;
                    end
                    PH_DATA: begin
                        if (n_flags_left == '0 || n_flags_left > 6'd32) begin
                            n_flags_left = '0;
                            flag_reload  = 1'b1;
                        end else begin
                            n_flags_left = n_flags_left - 6'd1;
                            if (!r_flag_word[n_flags_left[4:0]]) begin
                                lit_hit = 1'b1;
                                n_count = n_count + CountW'(1);
                                n_wp    = (n_wp == LastAddr) ? '0 : n_wp + AW'(1);
                                n_phase = (n_flags_left != '0) ? PH_DATA : PH_FLAG0;
                            end else begin
                                n_tok_lo = i_item.data;
                                n_phase  = PH_TOK_HI;
                            end
                        end
                    end
                    PH_TOK_HI: begin
                        n_dist = tok[15:3];
                        if (tok[2:0] != 3'd7) begin
                            do_match = 1'b1;
                            mlen     = CountW'(tok[2:0]) + 17'd3;
                        end else if (r_nib_held) begin
                            n_nib_held = 1'b0;
                            if (r_held_nib != 4'd15) begin
                                do_match = 1'b1;
                                mlen     = CountW'(r_held_nib) + 17'd10;
                            end else begin
                                n_phase = PH_EXT_BYTE;
                            end
                        end else begin
                            n_phase = PH_NIBBLE;
                        end
                    end
                    PH_NIBBLE: begin
                        n_nib_held = 1'b1;
                        n_held_nib = i_item.data[7:4];
                        if (i_item.data[3:0] != 4'd15) begin
                            do_match = 1'b1;
                            mlen     = CountW'(i_item.data[3:0]) + 17'd10;
                        end else begin
                            n_phase = PH_EXT_BYTE;
                        end
                    end
                    PH_EXT_BYTE: begin
                        if (i_item.data != 8'd255) begin
                            do_match = 1'b1;
                            mlen     = CountW'(i_item.data) + 17'd25;
                        end else begin
                            n_phase = PH_EXT16_LO;
                        end
                    end
                    PH_EXT16_LO: begin
                        n_tok_lo = i_item.data;
                        n_phase  = PH_EXT16_HI;
                    end
                    PH_EXT16_HI: begin
                        do_match = 1'b1;
                        mlen     = CountW'(tok) + 17'd3;
                    end
                    default: flag_reload = 1'b1;
                endcase
                if (flag_reload) begin
                    n_flag_word = {24'd0, i_item.data};
                    n_phase     = PH_FLAG1;
                end
                if (do_match) begin
                    n_phase = (n_flags_left != '0) ? PH_DATA : PH_FLAG0;
                    if (CountW'({1'b0, n_dist} + 14'd1) > n_count) status = ST_BAD_DIST;
                    else n_remain = mlen;
                end
                if (i_item.last) begin
                    n_ended = 1'b1;
                    if (n_phase != PH_FLAG0 && n_phase != PH_DATA) begin
                        status       = ST_TRUNCATED;
                        n_phase      = PH_FLAG0;
                        n_flags_left = '0;
                    end
                end
            end
        end
        produce = tick_hit || lit_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAG0;
            r_flag_word  <= '0;
            r_flags_left <= '0;
            r_tok_lo     <= '0;
            r_dist       <= '0;
            r_remain     <= '0;
            r_nib_held   <= 1'b0;
            r_held_nib   <= '0;
            r_count      <= '0;
            r_wp         <= '0;
            r_ended      <= 1'b0;
            r_res_valid  <= 1'b0;
            r_wr_pend    <= 1'b0;
        end else begin
            r_wr_pend <= take && produce;
            if (take) begin
                r_phase      <= n_phase;
                r_flag_word  <= n_flag_word;
                r_flags_left <= n_flags_left;
                r_tok_lo     <= n_tok_lo;
                r_dist       <= n_dist;
                r_remain     <= n_remain;
                r_nib_held   <= n_nib_held;
                r_held_nib   <= n_held_nib;
                r_count      <= n_count;
                r_wp         <= n_wp;
                r_ended      <= n_ended;
            end
            if (advance) r_res_valid <= i_item_valid;
        end
    end

    // Result fields and the write slot of the byte being produced.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s2_tick     <= tick_hit;
            r_s2_lit      <= lit_hit;
            r_s2_lit_byte <= lit_hit ? i_item.data : 8'd0;
            r_s2_byp      <= byp;
            r_s2_byp_data <= s2_byte;
            r_s2_pending  <= (n_remain != '0);
            r_s2_done     <= (n_ended && n_remain == '0) || (n_count >= lim);
            r_s2_status   <= status;
            r_s2_count    <= n_count;
            r_wr_addr     <= (i_item.kind == KIND_TICK) ? r_wp :
                             ((r_ended && r_remain == '0) ? '0 : r_wp);
        end
    end

    // History window: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) mem[r_wr_addr] <= s2_byte;
        if (take) r_rd_data <= mem[rd_addr];
    end

    assign o_valid         = r_res_valid;
    assign o_out_valid     = r_s2_tick || r_s2_lit;
    assign o_out_byte      = s2_byte;
    assign o_copy_pending  = r_s2_pending;
    assign o_block_done    = r_s2_done;
    assign o_status        = r_s2_status;
    assign o_decoded_count = r_s2_count;

endmodule

@@ rtl/xpress_lz77_decompressor_top.sv @@
// Top level of the plain Xpress LZ77 decompressor: configuration port,
// request queue (xlz_front) and decode engine (xlz_back). Depends on xlz_pkg.
//
// The block decodes a plain Xpress LZ77 stream. Each request is either one
// compressed byte or one tick that asks for the next byte of a pending match
// copy; every request gives exactly one result. A request queue in front lets
// the requester keep sending while the decode engine is stalled by the result
// side, and the engine registers its result so that both sides stall on their
// own. The engine takes one request per clock cycle in steady state, bytes and
// ticks alike, while the result side accepts results; a request is written
// into the queue, then decoded with the history read into the result register.
// The history window
// is a single RAM with one write and one read port; a copy whose source is the
// byte written just before is forwarded around the RAM. The output limit
// register sits at byte address 0 and takes effect for later requests; it is
// only to be written while no request is in flight. The history RAM is not
// cleared, and needs no clearing pass: bad distances are rejected before any
// unwritten entry could be read.
module xpress_lz77_decompressor_top
    import xlz_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH   = 8192,
    parameter int unsigned MAX_BLOCK_BYTES = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic              i_req_type,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_copy_pending,
    output logic              o_block_done,
    output logic [2:0]        o_status,
    output logic [CountW-1:0] o_decoded_count
);

    logic [CountW-1:0] r_limit;
    logic              item_valid, item_ready;
    t_item             item;

    // Configuration: the register is written in the access phase of a write.
    assign pready = 1'b1;
    assign prdata = (paddr[2:1] == RegOutputLimit) ? {15'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 17'd65536;
        end else if (psel && penable && pwrite && paddr[2:1] == RegOutputLimit) begin
            r_limit <= pwdata[CountW-1:0];
        end
    end

    xlz_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req_valid),
        .o_ready      (o_req_ready),
        .i_req_type   (i_req_type),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    xlz_back #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_valid),
        .o_item_ready    (item_ready),
        .i_item          (item),
        .i_limit         (r_limit),
        .o_valid         (o_res_valid),
        .i_ready         (i_res_ready),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_copy_pending  (o_copy_pending),
        .o_block_done    (o_block_done),
        .o_status        (o_status),
        .o_decoded_count (o_decoded_count)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for xpress_lz77_decompressor_top.
// Depends on xlz_pkg and the decompressor RTL; it builds Xpress LZ77 streams,
// predicts every result in its own decoder model and checks the result port.
module tb
    import xlz_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HistDepth  = 8192;
    localparam int BlockMax   = 65536;
    localparam int CycleLimit = 1500000;

    // One decoded result as the block reports it.
    typedef struct packed {
        logic             out_valid;
        logic [7:0]       out_byte;
        logic             copy_pending;
        logic             block_done;
        t_status          status;
        logic [CountW-1:0] count;
    } t_result;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       is_last;
    } t_request;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_req_valid = 1'b0;
    logic              o_req_ready;
    logic              i_req_type = 1'b0;
    logic [7:0]        i_in_byte = '0;
    logic              i_in_last = 1'b0;
    logic              o_res_valid;
    logic              i_res_ready = 1'b0;
    logic              o_out_valid;
    logic [7:0]        o_out_byte;
    logic              o_copy_pending;
    logic              o_block_done;
    logic [2:0]        o_status;
    logic [CountW-1:0] o_decoded_count;

    xpress_lz77_decompressor_top dut (.*);

    always #2 i_clk = ~i_clk;

    // Requests waiting to be driven and results still owed by the block.
    t_request request_queue[$];
    t_result  owed_results[$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    bit       hold_request = 1'b0;
    bit       hold_done = 1'b0;
    bit       recv_long_hold = 1'b0;
    int       recv_hold_cycles = 0;
    int       cycle_count = 0;

    // Decoder model state. It runs in request order, so it is safe to step it
    // as each request is queued: requests reach the block in the same order.
    t_phase      phase;
    logic [31:0] flag_bits;
    int          flags_left;
    logic [7:0]  token_lo;
    logic [12:0] distance;
    int          copy_left;
    bit          nibble_held;
    logic [3:0]  high_nibble;
    int          decoded;
    logic [7:0]  history[HistDepth];
    bit          input_done;
    int          limit_reg;

    function automatic int active_limit();
        return (limit_reg > BlockMax) ? BlockMax : limit_reg;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        history[decoded % HistDepth] = b;
        decoded++;
    endfunction

    function automatic void after_item();
        phase = (flags_left != 0) ? PH_DATA : PH_FLAG0;
    endfunction

    function automatic t_status begin_copy(int len);
        after_item();
        if (int'(distance) + 1 > decoded) return ST_BAD_DIST;
        copy_left = len & 32'h1FFFF;
        return ST_OK;
    endfunction

    // Parses one compressed byte; sets is_lit when the byte is a literal.
    function automatic t_status parse_byte(logic [7:0] b, output bit is_lit);
        logic [15:0] tok;
        is_lit = 1'b0;
        // A data byte with no flags left starts the next flag word.
        if (phase == PH_DATA && (flags_left == 0 || flags_left > 32)) begin
            flags_left = 0;
            phase = PH_FLAG0;
        end
        case (phase)
            PH_FLAG1: begin flag_bits[15:8] = b; phase = PH_FLAG2; end
            PH_FLAG2: begin flag_bits[23:16] = b; phase = PH_FLAG3; end
            PH_FLAG3: begin
                flag_bits[31:24] = b;
                flags_left = 32;
                phase = PH_DATA;
            end
            PH_DATA: begin
                flags_left--;
                if (flag_bits[flags_left] == 1'b0) begin
                    is_lit = 1'b1;
                    emit_byte(b);
                    after_item();
                end else begin
                    token_lo = b;
                    phase = PH_TOK_HI;
                end
            end
            PH_TOK_HI: begin
                tok = {b, token_lo};
                distance = tok[15:3];
                if (tok[2:0] != 3'd7) return begin_copy(int'(tok[2:0]) + 3);
                if (nibble_held) begin
                    nibble_held = 1'b0;
                    if (high_nibble != 4'd15) return begin_copy(int'(high_nibble) + 10);
                    phase = PH_EXT_BYTE;
                end else begin
                    phase = PH_NIBBLE;
                end
            end
            PH_NIBBLE: begin
                nibble_held = 1'b1;
                high_nibble = b[7:4];
                if (b[3:0] != 4'd15) return begin_copy(int'(b[3:0]) + 10);
                phase = PH_EXT_BYTE;
            end
            PH_EXT_BYTE: begin
                if (b != 8'hFF) return begin_copy(int'(b) + 25);
                phase = PH_EXT16_LO;
            end
            PH_EXT16_LO: begin token_lo = b; phase = PH_EXT16_HI; end
            PH_EXT16_HI: return begin_copy(int'({b, token_lo}) + 3);
            default: begin
                flag_bits = {24'd0, b};
                phase = PH_FLAG1;
            end
        endcase
        return ST_OK;
    endfunction

    function automatic t_result decode_step(t_request rq);
        t_result r;
        bit      is_lit;
        int      lim;
        r = '0;
        r.status = ST_OK;
        if (rq.kind == KIND_TICK) begin
            lim = active_limit();
            if (copy_left != 0) begin
                if (decoded >= lim) begin
                    copy_left = 0;
                end else begin
                    r.out_byte = history[(decoded + HistDepth - (int'(distance) + 1))
                                         % HistDepth];
                    r.out_valid = 1'b1;
                    emit_byte(r.out_byte);
                    copy_left--;
                    if (decoded >= lim) copy_left = 0;
                end
            end
        end else begin
            // A byte after a finished block opens a new block.
            if (input_done && copy_left == 0) begin
                phase = PH_FLAG0;
                flags_left = 0;
                nibble_held = 1'b0;
                high_nibble = '0;
                decoded = 0;
                input_done = 1'b0;
            end
            lim = active_limit();
            if (copy_left != 0) begin
                r.status = ST_COPY_BUSY;
            end else if (decoded >= lim) begin
                r.status = ST_PAST_LIM;
                if (rq.is_last) input_done = 1'b1;
            end else begin
                r.status = parse_byte(rq.data, is_lit);
                if (is_lit) begin
                    r.out_valid = 1'b1;
                    r.out_byte = rq.data;
                end
                if (rq.is_last) begin
                    input_done = 1'b1;
                    if (phase != PH_FLAG0 && phase != PH_DATA) begin
                        r.status = ST_TRUNCATED;
                        phase = PH_FLAG0;
                        flags_left = 0;
                    end
                end
            end
        end
        r.copy_pending = (copy_left != 0);
        r.block_done = (input_done && copy_left == 0) || decoded >= active_limit();
        r.count = decoded[CountW-1:0];
        return r;
    endfunction

    task automatic queue_request(t_kind kind, logic [7:0] b, logic is_last);
        t_request rq;
        rq.kind = kind;
        rq.data = b;
        rq.is_last = is_last;
        request_queue.push_back(rq);
        owed_results.push_back(decode_step(rq));
    endtask

    // Sends ticks until the pending copy is drained, with an occasional stray
    // byte in between, which the block must ignore.
    task automatic drain_copy();
        while (copy_left != 0) begin
            if ($urandom_range(0, 99) < 4)
                queue_request(KIND_BYTE, 8'($urandom), 1'($urandom));
            queue_request(KIND_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    // Builds one block of compressed bytes, sometimes cut short and sometimes with
    // bad distances, and queues it with the ticks that its matches need.
    task automatic send_block(int groups, bit long_ok);
        logic [7:0]  stream[$];
        logic [31:0] flags;
        logic [15:0] tok;
        int          made;
        int          code;
        int          len;
        int          nib;
        int          ext;
        int          val;
        int          src_dist;
        int          cut;
        int          lim_items;
        bit          held;
        logic [3:0]  held_val;
        made = 0;
        held = 1'b0;
        held_val = '0;
        for (int g = 0; g < groups; g++) begin
            flags = $urandom;
            for (int k = 0; k < 4; k++) stream.push_back(flags[8*k +: 8]);
            lim_items = (g == groups - 1 && $urandom_range(0, 2) == 0)
                        ? $urandom_range(1, 32) : 32;
            for (int i = 31; i >= 32 - lim_items; i--) begin
                if (!flags[i]) begin
                    stream.push_back(8'($urandom));
                    made++;
                    continue;
                end
                if (made > 0 && $urandom_range(0, 9) != 0)
                    src_dist = $urandom_range(0, (made > HistDepth ? HistDepth : made) - 1);
                else
                    src_dist = $urandom_range(made, made + 20) % HistDepth;
                code = $urandom_range(0, 7);
                tok = {13'(src_dist), 3'(code)};
                stream.push_back(tok[7:0]);
                stream.push_back(tok[15:8]);
                if (code < 7) begin
                    len = code + 3;
                end else begin
                    if (held) begin
                        held = 1'b0;
                        nib = held_val;
                    end else begin
                        nib = ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(0, 15);
                        held_val = 4'($urandom);
                        held = 1'b1;
                        stream.push_back({held_val, 4'(nib)});
                    end
                    if (nib != 15) begin
                        len = nib + 10;
                    end else begin
                        ext = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 254);
                        if (!long_ok && ext != 255) ext = ext % 30;
                        stream.push_back(8'(ext));
                        if (ext != 255) begin
                            len = ext + 25;
                        end else begin
                            val = long_ok ? $urandom_range(0, 65535) : $urandom_range(0, 30);
                            stream.push_back(8'(val));
                            stream.push_back(8'(val >> 8));
                            len = val + 3;
                        end
                    end
                end
                if (src_dist + 1 <= made) made += len;
            end
        end
        // Now and then the block is cut short at a random byte.
        cut = stream.size();
        if ($urandom_range(0, 6) == 0) cut = $urandom_range(1, stream.size());
        for (int i = 0; i < cut; i++) begin
            queue_request(KIND_BYTE, stream[i], i == cut - 1);
            drain_copy();
        end
        if ($urandom_range(0, 9) == 0) queue_request(KIND_TICK, 8'($urandom), 1'b0);
    endtask

    // Waits until every queued request has been answered and the engine has
    // had time to settle.
    task automatic wait_drained();
        while (request_queue.size() != 0 || i_req_valid || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(int value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * RegOutputLimit);
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_reg = value & 32'h1FFFF;
    endtask

    // Request driver: a new request is put up only when the previous one was
    // taken at this edge or none was up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (!i_req_valid || o_req_ready) begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_request rq;
                rq = request_queue.pop_front();
                i_req_valid <= 1'b1;
                i_req_type <= rq.kind;
                i_in_byte <= rq.data;
                i_in_last <= rq.is_last;
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps going.
    always @(posedge i_clk) begin
        if (hold_request && !hold_done) begin
            recv_long_hold <= 1'b1;
            recv_hold_cycles <= 400;
            hold_done <= 1'b1;
        end else if (recv_hold_cycles > 1) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else if (recv_hold_cycles == 1) begin
            recv_hold_cycles <= 0;
            recv_long_hold <= 1'b0;
        end
    end

    // Result monitor: compares each accepted result with the oldest one owed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result with none owed: %p", o_status);
                end else begin
                    t_result want;
                    t_result got;
                    want = owed_results.pop_front();
                    got = {o_out_valid, o_out_byte, o_copy_pending, o_block_done,
                           t_status'(o_status), o_decoded_count};
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            i_res_ready <= !recv_long_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("** xpress_lz77_decompressor_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int limits[6];
        int phase_items;
        limits = '{131071, 1, 0, 40, 300, 65536};
        limit_reg = 65536;
        phase = PH_FLAG0;
        flag_bits = '0;
        flags_left = 0;
        token_lo = '0;
        distance = '0;
        copy_left = 0;
        nibble_held = 1'b0;
        high_nibble = '0;
        decoded = 0;
        input_done = 1'b0;
        for (int i = 0; i < HistDepth; i++) history[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed block: an idle tick, then flag word 0x60000000 with a literal,
        // a nibble-extended match, a match through the held nibble into the
        // byte and 16-bit extensions, and a closing literal.
        queue_request(KIND_TICK, 8'h00, 1'b0);
        queue_request(KIND_BYTE, 8'h00, 1'b0);
        queue_request(KIND_BYTE, 8'h00, 1'b0);
        queue_request(KIND_BYTE, 8'h00, 1'b0);
        queue_request(KIND_BYTE, 8'h60, 1'b0);
        queue_request(KIND_BYTE, 8'hFF, 1'b0);
        queue_request(KIND_BYTE, 8'h07, 1'b0);
        queue_request(KIND_BYTE, 8'h00, 1'b0);
        queue_request(KIND_BYTE, 8'hF2, 1'b0);
        drain_copy();
        queue_request(KIND_BYTE, 8'h07, 1'b0);
        queue_request(KIND_BYTE, 8'h00, 1'b0);
        queue_request(KIND_BYTE, 8'hFF, 1'b0);
        queue_request(KIND_BYTE, 8'h05, 1'b0);
        queue_request(KIND_BYTE, 8'h00, 1'b0);
        drain_copy();
        queue_request(KIND_BYTE, 8'h00, 1'b1);
        wait_drained();

        phase_items = 0;
        foreach (limits[p]) begin
            write_limit(limits[p]);
            // The idling mix changes across the run; the second phase also
            // stalls the result side for a long stretch to fill the block.
            send_idle_pct = (p < 2) ? 21 : (p < 4) ? 77 : 0;
            recv_idle_pct = (p < 2) ? 77 : (p < 4) ? 21 : 0;
            if (p == 1) hold_request = 1'b1;
            phase_items = owed_results.size() + 120;
            while (owed_results.size() < phase_items) begin
                if ($urandom_range(0, 19) == 0) begin
                    // Unstructured bytes, each of which may end a block.
                    repeat ($urandom_range(1, 12))
                        queue_request(KIND_BYTE, 8'($urandom), $urandom_range(0, 5) == 0);
                    drain_copy();
                end else begin
                    send_block($urandom_range(1, 2), limits[p] <= 300);
                end
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("** xpress_lz77_decompressor_top: PASSED **");
        end else begin
            $display("** xpress_lz77_decompressor_top: FAILED **");
        end
        $finish;
    end
endmodule
